@@ src/tvb_pkg.sv @@
// Package for the triangle vertex batcher: field widths, record kinds,
// register indexes, FSM states and the lane merge result type.
// No dependencies.
`default_nettype none
package tvb_pkg;

  localparam int IDX_W          = 16;
  localparam int SLOT_W         = 5;
  localparam int VCNT_W         = 6;
  localparam int TCNT_W         = 7;
  localparam int CFG_W          = 7;
  localparam int SLOT_DEPTH     = 32;
  localparam int TRI_CAP        = 64;
  localparam int BATCH_VERTS_DEF    = 32;
  localparam int MAX_BATCH_TRIS_DEF = 64;
  localparam int VLIM_RESET     = 32;
  localparam int TLIM_RESET     = 64;
  localparam int VLIM_MIN       = 3;

  typedef enum logic [1:0] {
    REC_VERT  = 2'd0,
    REC_TRI   = 2'd1,
    REC_CLOSE = 2'd2
  } rec_kind_e;

  typedef enum logic [0:0] {
    CFG_VERTEX_LIMIT = 1'b0,
    CFG_TRI_LIMIT    = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MERGE,
    S_CLOSE0,
    S_VERT0,
    S_VERT1,
    S_VERT2,
    S_TRI,
    S_CLOSE1
  } state_e;

  // Placement plan for one triangle, built by the merge stage
  typedef struct packed {
    logic                   close_first;
    logic [2:0]             is_new;
    logic [2:0][SLOT_W-1:0] slot;
  } plan_t;

endpackage
`default_nettype wire

@@ src/tvb_if.sv @@
// Valid/ready channel interfaces for triangle items and result records.
// Depends on tvb_pkg.
`default_nettype none
interface tvb_in_if import tvb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] idx0;
  logic [IDX_W-1:0] idx1;
  logic [IDX_W-1:0] idx2;
  logic             end_of_mesh;

  modport source (output valid, idx0, idx1, idx2, end_of_mesh, input ready);
  modport sink   (input valid, idx0, idx1, idx2, end_of_mesh, output ready);
endinterface

interface tvb_out_if import tvb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        rec_kind;
  logic [SLOT_W-1:0] vert_slot;
  logic [IDX_W-1:0]  vert_source;
  logic [SLOT_W-1:0] slot_a;
  logic [SLOT_W-1:0] slot_b;
  logic [SLOT_W-1:0] slot_c;
  logic [VCNT_W-1:0] batch_verts;
  logic [TCNT_W-1:0] batch_tris;
  logic              last;

  modport source (output valid, rec_kind, vert_slot, vert_source, slot_a, slot_b, slot_c,
                  batch_verts, batch_tris, last, input ready);
  modport sink   (input valid, rec_kind, vert_slot, vert_source, slot_a, slot_b, slot_c,
                  batch_verts, batch_tris, last, output ready);
endinterface
`default_nettype wire

@@ src/tvb_lane.sv @@
// One slot lane: holds one slot table entry and compares it against the
// three corner indices of the incoming triangle. Depends on tvb_pkg.
`default_nettype none
module tvb_lane import tvb_pkg::*; #(
  parameter int LANE = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   wr_en_i,
  input  wire logic [SLOT_W-1:0]      wr_slot_i,
  input  wire logic [IDX_W-1:0]       wr_data_i,
  input  wire logic [VCNT_W-1:0]      cnt_i,
  input  wire logic [2:0][IDX_W-1:0]  key_i,
  output logic      [2:0]             hit_o
);

  logic [IDX_W-1:0] entry_q;
  logic [2:0]       hit_q;
  logic             live;

  assign live  = cnt_i > VCNT_W'(LANE);
  assign hit_o = hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_slot_i == SLOT_W'(LANE))) begin
      entry_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      hit_q[c] <= live && (entry_q == key_i[c]);
    end
  end

endmodule
`default_nettype wire

@@ src/tvb_merge.sv @@
// Merge stage: encodes the lane hits per corner, counts new vertices,
// decides on a leading batch close and assigns local slots.
// Depends on tvb_pkg.
`default_nettype none
module tvb_merge import tvb_pkg::*; #(
  parameter int DEPTH = SLOT_DEPTH
) (
  input  wire logic [2:0][DEPTH-1:0]  match_i,
  input  wire logic [2:0][IDX_W-1:0]  key_i,
  input  wire logic [VCNT_W-1:0]      cnt_i,
  input  wire logic [TCNT_W-1:0]      tris_i,
  input  wire logic [VCNT_W-1:0]      vlim_i,
  input  wire logic [TCNT_W-1:0]      tlim_i,
  output plan_t                       plan_o
);

  logic [2:0]             hit;
  logic [2:0]             h;
  logic [2:0][SLOT_W-1:0] enc;
  logic                   eq01, eq02, eq12;
  logic [1:0]             needed;
  logic [VCNT_W:0]        sum;
  logic                   close;
  logic [2:0]             nw;
  logic [SLOT_W-1:0]      base;
  logic [2:0][SLOT_W-1:0] s;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hit[c] = |match_i[c];
      enc[c] = '0;
      for (int j = 0; j < DEPTH; j++) begin
        if (match_i[c][j]) begin
          enc[c] = enc[c] | SLOT_W'(j);
        end
      end
    end
  end

  assign eq01 = key_i[0] == key_i[1];
  assign eq02 = key_i[0] == key_i[2];
  assign eq12 = key_i[1] == key_i[2];

  assign needed = 2'(!hit[0]) + 2'(!hit[1] && !eq01) + 2'(!hit[2] && !eq02 && !eq12);
  assign sum    = {1'b0, cnt_i} + (VCNT_W+1)'(needed);
  assign close  = (cnt_i != '0) && ((sum > {1'b0, vlim_i}) || (tris_i >= tlim_i));

  assign h     = close ? 3'b000 : hit;
  assign nw[0] = !h[0];
  assign nw[1] = !h[1] && !eq01;
  assign nw[2] = !h[2] && !eq02 && !eq12;
  assign base  = close ? '0 : cnt_i[SLOT_W-1:0];

  always_comb begin
    s[0] = nw[0] ? base : enc[0];
    if (nw[1]) begin
      s[1] = base + SLOT_W'(nw[0]);
    end else if (h[1]) begin
      s[1] = enc[1];
    end else begin
      s[1] = s[0];
    end
    if (nw[2]) begin
      s[2] = base + SLOT_W'(nw[0]) + SLOT_W'(nw[1]);
    end else if (h[2]) begin
      s[2] = enc[2];
    end else if (eq02) begin
      s[2] = s[0];
    end else begin
      s[2] = s[1];
    end
  end

  assign plan_o.close_first = close;
  assign plan_o.is_new      = nw;
  assign plan_o.slot        = s;

endmodule
`default_nettype wire

@@ src/triangle_vertex_batcher_core.sv @@
// Top level of the triangle vertex batcher: configuration, slot lanes,
// merge stage, record sequencer and output register.
// Depends on tvb_pkg, tvb_if, tvb_lane and tvb_merge.
//
// One triangle is taken at a time. In the transfer cycle the slot lanes
// compare all open entries against the three corners, the merge stage plans
// the placement in the next cycle, and the sequencer then issues one record
// per cycle while the output register can take it: N = 1..6 records per
// triangle (close, up to three new vertices, triangle, end-of-mesh close).
// A new triangle is taken while the last record still waits in the output
// register. There is no clearing pass: only slots below the open vertex
// count are ever matched.
`default_nettype none
module triangle_vertex_batcher_core import tvb_pkg::*; #(
  parameter int BATCH_VERTS    = BATCH_VERTS_DEF,
  parameter int MAX_BATCH_TRIS = MAX_BATCH_TRIS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  tvb_in_if.sink                 in_i,
  tvb_out_if.source              out_o
);

  localparam int VLIM_CAP = (BATCH_VERTS < SLOT_DEPTH) ? BATCH_VERTS : SLOT_DEPTH;
  localparam int TLIM_CAP = (MAX_BATCH_TRIS < TRI_CAP) ? MAX_BATCH_TRIS : TRI_CAP;

  state_e                 state_q, state_d, nxt_seq;
  logic [VCNT_W-1:0]      vlimit_q;
  logic [TCNT_W-1:0]      tlimit_q;
  logic [VCNT_W-1:0]      vlim_eff;
  logic [TCNT_W-1:0]      tlim_eff;
  logic [VCNT_W-1:0]      cnt_q, cnt_d;
  logic [TCNT_W-1:0]      tris_q, tris_d;
  logic [2:0][IDX_W-1:0]  in_key;
  logic [2:0][IDX_W-1:0]  keys_q;
  logic                   eom_q;
  plan_t                  plan_c, plan_q;
  logic [VLIM_CAP-1:0][2:0] lane_hit;
  logic [2:0][VLIM_CAP-1:0] match;
  logic                   accept;
  logic                   out_free;
  logic                   emit;
  logic                   wr_en;
  logic [1:0]             vk;
  logic [SLOT_W-1:0]      vslot;

  logic                   out_valid_q;
  rec_kind_e              kind_d, kind_q;
  logic [SLOT_W-1:0]      vslot_d, vslot_q;
  logic [IDX_W-1:0]       vsrc_d, vsrc_q;
  logic [2:0][SLOT_W-1:0] tslot_d, tslot_q;
  logic [VCNT_W-1:0]      bverts_d, bverts_q;
  logic [TCNT_W-1:0]      btris_d, btris_q;
  logic                   last_d, last_q;

  // effective limits
  always_comb begin
    vlim_eff = vlimit_q;
    if (vlim_eff < VCNT_W'(VLIM_MIN)) vlim_eff = VCNT_W'(VLIM_MIN);
    if (vlim_eff > VCNT_W'(VLIM_CAP)) vlim_eff = VCNT_W'(VLIM_CAP);
    tlim_eff = tlimit_q;
    if (tlim_eff == '0) tlim_eff = TCNT_W'(1);
    if (tlim_eff > TCNT_W'(TLIM_CAP)) tlim_eff = TCNT_W'(TLIM_CAP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlimit_q <= VCNT_W'(VLIM_RESET);
      tlimit_q <= TCNT_W'(TLIM_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VERTEX_LIMIT: vlimit_q <= cfg_data_i[VCNT_W-1:0];
        CFG_TRI_LIMIT:    tlimit_q <= cfg_data_i[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_key[0] = in_i.idx0;
  assign in_key[1] = in_i.idx1;
  assign in_key[2] = in_i.idx2;
  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      keys_q <= in_key;
      eom_q  <= in_i.end_of_mesh;
    end
    if (state_q == S_MERGE) begin
      plan_q <= plan_c;
    end
  end

  // slot lanes
  for (genvar j = 0; j < VLIM_CAP; j++) begin : g_lane
    tvb_lane #(.LANE(j)) u_lane (
      .clk_i     (clk_i),
      .wr_en_i   (wr_en),
      .wr_slot_i (vslot),
      .wr_data_i (keys_q[vk]),
      .cnt_i     (cnt_q),
      .key_i     (in_key),
      .hit_o     (lane_hit[j])
    );
    for (genvar c = 0; c < 3; c++) begin : g_corner
      assign match[c][j] = lane_hit[j][c];
    end
  end

  tvb_merge #(.DEPTH(VLIM_CAP)) u_merge (
    .match_i (match),
    .key_i   (keys_q),
    .cnt_i   (cnt_q),
    .tris_i  (tris_q),
    .vlim_i  (vlim_eff),
    .tlim_i  (tlim_eff),
    .plan_o  (plan_c)
  );

  assign out_free = !out_valid_q || out_o.ready;

  // record order successor
  always_comb begin
    nxt_seq = S_IDLE;
    case (state_q)
      S_MERGE: begin
        if (plan_c.close_first)    nxt_seq = S_CLOSE0;
        else if (plan_c.is_new[0]) nxt_seq = S_VERT0;
        else if (plan_c.is_new[1]) nxt_seq = S_VERT1;
        else if (plan_c.is_new[2]) nxt_seq = S_VERT2;
        else                       nxt_seq = S_TRI;
      end
      S_CLOSE0: begin
        if (plan_q.is_new[0])      nxt_seq = S_VERT0;
        else if (plan_q.is_new[1]) nxt_seq = S_VERT1;
        else if (plan_q.is_new[2]) nxt_seq = S_VERT2;
        else                       nxt_seq = S_TRI;
      end
      S_VERT0: begin
        if (plan_q.is_new[1])      nxt_seq = S_VERT1;
        else if (plan_q.is_new[2]) nxt_seq = S_VERT2;
        else                       nxt_seq = S_TRI;
      end
      S_VERT1:  nxt_seq = plan_q.is_new[2] ? S_VERT2 : S_TRI;
      S_VERT2:  nxt_seq = S_TRI;
      S_TRI:    nxt_seq = eom_q ? S_CLOSE1 : S_IDLE;
      S_CLOSE1: nxt_seq = S_IDLE;
      default:  nxt_seq = S_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_MERGE;
      S_MERGE: state_d = nxt_seq;
      S_CLOSE0, S_VERT0, S_VERT1, S_VERT2, S_TRI, S_CLOSE1: begin
        if (out_free) state_d = nxt_seq;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      S_VERT1: vk = 2'd1;
      S_VERT2: vk = 2'd2;
      default: vk = 2'd0;
    endcase
  end
  assign vslot = plan_q.slot[vk];

  // outputs
  always_comb begin
    emit     = 1'b0;
    wr_en    = 1'b0;
    cnt_d    = cnt_q;
    tris_d   = tris_q;
    kind_d   = REC_TRI;
    vslot_d  = '0;
    vsrc_d   = '0;
    tslot_d  = '0;
    bverts_d = '0;
    btris_d  = '0;
    last_d   = (nxt_seq == S_IDLE);
    case (state_q)
      S_CLOSE0, S_CLOSE1: begin
        emit     = out_free;
        kind_d   = REC_CLOSE;
        bverts_d = cnt_q;
        btris_d  = tris_q;
        if (out_free) begin
          cnt_d  = '0;
          tris_d = '0;
        end
      end
      S_VERT0, S_VERT1, S_VERT2: begin
        emit    = out_free;
        wr_en   = out_free;
        kind_d  = REC_VERT;
        vslot_d = vslot;
        vsrc_d  = keys_q[vk];
        if (out_free) cnt_d = cnt_q + VCNT_W'(1);
      end
      S_TRI: begin
        emit    = out_free;
        kind_d  = REC_TRI;
        tslot_d = plan_q.slot;
        if (out_free) tris_d = tris_q + TCNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tris_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tris_q  <= tris_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q   <= kind_d;
      vslot_q  <= vslot_d;
      vsrc_q   <= vsrc_d;
      tslot_q  <= tslot_d;
      bverts_q <= bverts_d;
      btris_q  <= btris_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.rec_kind    = kind_q;
  assign out_o.vert_slot   = vslot_q;
  assign out_o.vert_source = vsrc_q;
  assign out_o.slot_a      = tslot_q[0];
  assign out_o.slot_b      = tslot_q[1];
  assign out_o.slot_c      = tslot_q[2];
  assign out_o.batch_verts = bverts_q;
  assign out_o.batch_tris  = btris_q;
  assign out_o.last        = last_q;

  // new vertices always land on the next free slot
  a_vert_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (state_q == S_VERT0 || state_q == S_VERT1 || state_q == S_VERT2))
      |-> (vslot == cnt_q[SLOT_W-1:0]))
    else $error("vertex placed off the free slot");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= VCNT_W'(VLIM_CAP))
    else $error("open vertex count beyond slot lanes");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (state_q == S_CLOSE0 || state_q == S_CLOSE1))
      |=> (cnt_q == '0 && tris_q == '0))
    else $error("batch close did not clear counts");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_d) |=> (state_q == S_IDLE))
    else $error("last record issued but sequencer busy");

  a_tri_never_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && state_q == S_TRI) |-> (cnt_q != '0))
    else $error("triangle record with empty batch");

endmodule
`default_nettype wire

@@ verif/tb_triangle_vertex_batcher_core.sv @@
`timescale 1ns / 100ps
// Testbench for triangle_vertex_batcher_core: directed and random triangle streams
// with random idling on both channels, each record checked against an in-bench batcher.
// Depends on tvb_pkg, tvb_if and the core RTL.
module tb_triangle_vertex_batcher_core;
  import tvb_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 16;

  typedef struct {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             eom;
  } tri_t;

  typedef struct {
    rec_kind_e         kind;
    logic [SLOT_W-1:0] vert_slot;
    logic [IDX_W-1:0]  vert_source;
    logic [SLOT_W-1:0] slot_a;
    logic [SLOT_W-1:0] slot_b;
    logic [SLOT_W-1:0] slot_c;
    logic [VCNT_W-1:0] batch_verts;
    logic [TCNT_W-1:0] batch_tris;
    logic              last;
  } rec_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  cfg_idx_e         cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  tvb_in_if  tri_if ();
  tvb_out_if rec_if ();

  triangle_vertex_batcher_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (tri_if),
    .out_o      (rec_if)
  );

  always #2 clk_i = ~clk_i;

  // batcher state and limits
  logic [IDX_W-1:0]  slot_src [SLOT_DEPTH];
  int unsigned       open_verts;
  int unsigned       open_tris;
  logic [VCNT_W-1:0] vlim_reg;
  logic [TCNT_W-1:0] tlim_reg;

  rec_t        expected_recs [$];
  tri_t        tri_q [$];
  int unsigned tris_pending;
  int unsigned fail_cnt;
  int unsigned idle_cycles;
  int          send_gap;
  int          stall_left;
  bit          send_steady;
  bit          recv_steady;

  function automatic int find_slot_of(logic [IDX_W-1:0] src);
    for (int i = 0; i < open_verts; i++) begin
      if (slot_src[i] == src) return i;
    end
    return -1;
  endfunction

  function automatic rec_t blank_rec(rec_kind_e kind);
    rec_t r;
    r.kind        = kind;
    r.vert_slot   = '0;
    r.vert_source = '0;
    r.slot_a      = '0;
    r.slot_b      = '0;
    r.slot_c      = '0;
    r.batch_verts = '0;
    r.batch_tris  = '0;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic rec_t close_batch();
    rec_t r;
    r = blank_rec(REC_CLOSE);
    r.batch_verts = VCNT_W'(open_verts);
    r.batch_tris  = TCNT_W'(open_tris);
    open_verts = 0;
    open_tris  = 0;
    return r;
  endfunction

  function automatic void place_triangle(tri_t t);
    logic [IDX_W-1:0]  corner [3];
    logic [SLOT_W-1:0] slot [3];
    rec_t              recs [6];
    int                n;
    int                s;
    int                fresh;
    int                vcap;
    int                tcap;
    bit                seen;
    corner[0] = t.a;
    corner[1] = t.b;
    corner[2] = t.c;
    vcap = (vlim_reg < VLIM_MIN) ? VLIM_MIN : int'(vlim_reg);
    if (vcap > BATCH_VERTS_DEF) vcap = BATCH_VERTS_DEF;
    if (vcap > SLOT_DEPTH) vcap = SLOT_DEPTH;
    tcap = (tlim_reg == 0) ? 1 : int'(tlim_reg);
    if (tcap > MAX_BATCH_TRIS_DEF) tcap = MAX_BATCH_TRIS_DEF;
    if (tcap > TRI_CAP) tcap = TRI_CAP;
    n = 0;
    fresh = 0;
    for (int i = 0; i < 3; i++) begin
      seen = find_slot_of(corner[i]) >= 0;
      for (int k = 0; k < i; k++) begin
        if (corner[k] == corner[i]) seen = 1'b1;
      end
      if (!seen) fresh++;
    end
    if (open_verts > 0 && (open_verts + fresh > vcap || open_tris >= tcap)) begin
      recs[n] = close_batch();
      n++;
    end
    for (int i = 0; i < 3; i++) begin
      s = find_slot_of(corner[i]);
      if (s < 0) begin
        s = open_verts;
        slot_src[s] = corner[i];
        open_verts++;
        recs[n] = blank_rec(REC_VERT);
        recs[n].vert_slot   = SLOT_W'(s);
        recs[n].vert_source = corner[i];
        n++;
      end
      slot[i] = SLOT_W'(s);
    end
    recs[n] = blank_rec(REC_TRI);
    recs[n].slot_a = slot[0];
    recs[n].slot_b = slot[1];
    recs[n].slot_c = slot[2];
    n++;
    open_tris = (open_tris + 1) & 32'h7F;
    if (t.eom) begin
      recs[n] = close_batch();
      n++;
    end
    for (int i = 0; i < n; i++) begin
      recs[i].last = (i == n - 1);
      expected_recs.push_back(recs[i]);
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // triangle driver
  always @(posedge clk_i) begin : tri_driver
    tri_t took;
    tri_t nxt;
    if (!rst_ni) begin
      tri_if.valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (tri_if.valid && tri_if.ready) begin
        took.a   = tri_if.idx0;
        took.b   = tri_if.idx1;
        took.c   = tri_if.idx2;
        took.eom = tri_if.end_of_mesh;
        place_triangle(took);
        tris_pending--;
      end
      if (!tri_if.valid || tri_if.ready) begin
        if (send_gap > 0) begin
          tri_if.valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (tri_q.size() != 0) begin
          nxt = tri_q.pop_front();
          tri_if.valid       <= 1'b1;
          tri_if.idx0        <= nxt.a;
          tri_if.idx1        <= nxt.b;
          tri_if.idx2        <= nxt.c;
          tri_if.end_of_mesh <= nxt.eom;
          send_gap           <= send_steady ? 0 : gap_len();
        end else begin
          tri_if.valid <= 1'b0;
        end
      end
    end
  end

  // record sink backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rec_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rec_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rec_if.ready <= 1'b1;
      stall_left   <= recv_steady ? 0 : gap_len();
    end
  end

  // record monitor
  always @(posedge clk_i) begin : rec_monitor
    rec_t want;
    if (rst_ni && rec_if.valid && rec_if.ready) begin
      if (expected_recs.size() == 0) begin
        $error("record with no triangle pending: rec_kind %0d", rec_if.rec_kind);
        fail_cnt++;
      end else begin
        want = expected_recs.pop_front();
        check_field("rec_kind", want.kind, rec_if.rec_kind);
        check_field("vert_slot", want.vert_slot, rec_if.vert_slot);
        check_field("vert_source", want.vert_source, rec_if.vert_source);
        check_field("slot_a", want.slot_a, rec_if.slot_a);
        check_field("slot_b", want.slot_b, rec_if.slot_b);
        check_field("slot_c", want.slot_c, rec_if.slot_c);
        check_field("batch_verts", want.batch_verts, rec_if.batch_verts);
        check_field("batch_tris", want.batch_tris, rec_if.batch_tris);
        check_field("last", want.last, rec_if.last);
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (tri_if.valid && tri_if.ready) || (rec_if.valid && rec_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_VERTEX_LIMIT) vlim_reg = val[VCNT_W-1:0];
    else tlim_reg = val[TCNT_W-1:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (tris_pending != 0 || expected_recs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_tri(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b, logic [IDX_W-1:0] c,
                         logic eom);
    tri_t t;
    t = '{a, b, c, eom};
    tri_q.push_back(t);
    tris_pending++;
  endtask

  // triangles drawn from a small window of indices so vertices are shared
  task automatic add_mesh(int n_tris, int span, bit closed);
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] c [3];
    base = IDX_W'($urandom);
    for (int i = 0; i < n_tris; i++) begin
      for (int k = 0; k < 3; k++) c[k] = base + IDX_W'($urandom_range(0, span));
      if ($urandom_range(0, 9) == 0) c[$urandom_range(1, 2)] = c[0];
      add_tri(c[0], c[1], c[2], closed && i == n_tris - 1);
    end
  endtask

  task automatic random_phase(int n_items);
    logic [CFG_W-1:0] vl;
    logic [CFG_W-1:0] tl;
    int               added;
    int               len;
    int               pick;
    case ($urandom_range(0, 4))
      0: vl = CFG_W'($urandom_range(0, 2));
      1: vl = CFG_W'(VLIM_MIN);
      2: vl = CFG_W'($urandom_range(33, 127));
      default: vl = CFG_W'($urandom_range(3, 32) | ($urandom_range(0, 1) << 6));
    endcase
    case ($urandom_range(0, 4))
      0: tl = '0;
      1: tl = CFG_W'(1);
      2: tl = CFG_W'(TRI_CAP);
      3: tl = CFG_W'($urandom_range(65, 127));
      default: tl = CFG_W'($urandom_range(1, 63));
    endcase
    write_reg(CFG_VERTEX_LIMIT, vl);
    write_reg(CFG_TRI_LIMIT, tl);
    send_steady = ($urandom_range(0, 3) == 0);
    recv_steady = ($urandom_range(0, 3) == 0);
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = $urandom_range(1, 15);
        add_mesh(len, ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(2, 8), 1'b1);
        added += len;
      end else if (pick < 9) begin
        add_tri(IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), $urandom_range(0, 1));
        added++;
      end else begin
        len = $urandom_range(1, 6);
        add_mesh(len, 6, 1'b0);
        added += len;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_VERTEX_LIMIT;
    cfg_data_i         = '0;
    tri_if.valid       = 1'b0;
    tri_if.idx0        = '0;
    tri_if.idx1        = '0;
    tri_if.idx2        = '0;
    tri_if.end_of_mesh = 1'b0;
    rec_if.ready       = 1'b0;
    fail_cnt           = 0;
    tris_pending       = 0;
    send_steady        = 1'b0;
    recv_steady        = 1'b0;
    vlim_reg           = VCNT_W'(VLIM_RESET);
    tlim_reg           = TCNT_W'(TLIM_RESET);
    open_verts         = 0;
    open_tris          = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // limits below range, one triangle per batch, repeated corners, extreme indices
    write_reg(CFG_VERTEX_LIMIT, 0);
    write_reg(CFG_TRI_LIMIT, 0);
    add_tri(0, 1, 2, 1'b0);
    add_tri(0, 1, 2, 1'b0);
    add_tri(5, 5, 5, 1'b0);
    add_tri(16'hFFFF, 0, 16'hFFFF, 1'b1);
    wait_idle();

    // vertex overflow closes; batch left open
    write_reg(CFG_VERTEX_LIMIT, 4);
    write_reg(CFG_TRI_LIMIT, TRI_CAP);
    add_tri(10, 11, 12, 1'b0);
    add_tri(12, 13, 14, 1'b0);
    add_tri(20, 20, 21, 1'b0);
    wait_idle();

    // triangle limit lowered under an open batch
    write_reg(CFG_TRI_LIMIT, 1);
    add_tri(21, 20, 21, 1'b0);
    wait_idle();

    // limits above range
    write_reg(CFG_VERTEX_LIMIT, 63);
    write_reg(CFG_TRI_LIMIT, 127);
    add_tri(16'hFFFF, 16'hFFFE, 16'hFFFD, 1'b0);
    add_tri(16'hFFFF, 16'hFFFE, 0, 1'b0);
    add_tri(7, 7, 7, 1'b1);
    add_tri(100, 101, 102, 1'b0);
    wait_idle();

    // vertex limit lowered under an open batch
    write_reg(CFG_VERTEX_LIMIT, 1);
    add_tri(100, 103, 100, 1'b1);
    wait_idle();

    // long mesh over few vertices: reaches the full triangle count
    write_reg(CFG_VERTEX_LIMIT, BATCH_VERTS_DEF);
    write_reg(CFG_TRI_LIMIT, TRI_CAP);
    send_steady = 1'b1;
    recv_steady = 1'b1;
    add_mesh(70, 3, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) random_phase(16);

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/tvb_pkg.sv
src/tvb_if.sv
src/tvb_lane.sv
src/tvb_merge.sv
src/triangle_vertex_batcher_core.sv
verif/tb_triangle_vertex_batcher_core.sv
